// ===== rtl/bppc_pkg.sv =====
// types and constants for the battery pack protection controller
`default_nettype none

package bppc_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MEASURE = 2'd1,
    OP_COMMAND = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_CHG   = 2'd0,
    CFG_MAX_DCHG  = 2'd1,
    CFG_WIN_TICKS = 2'd2,
    CFG_PRESS_THR = 2'd3
  } cfg_e;

  // remote command bytes
  localparam logic [7:0] CMD_RELAY1 = 8'h01;
  localparam logic [7:0] CMD_RELAY2 = 8'h02;
  localparam logic [7:0] CMD_FAN1   = 8'h03;
  localparam logic [7:0] CMD_FAN2   = 8'h04;

  // register widths and reset values
  localparam int unsigned CurW = 15;
  localparam int unsigned CntW = 8;
  localparam logic [CurW-1:0] MAX_CHG_RST   = 15'd1000;
  localparam logic [CurW-1:0] MAX_DCHG_RST  = 15'd1000;
  localparam logic [CntW-1:0] WIN_TICKS_RST = 8'd40;
  localparam logic [CntW-1:0] PRESS_THR_RST = 8'd10;
  localparam logic [CntW-1:0] CNT_MAX       = 8'hFF;

  // one input word
  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         button_levels;
    logic signed [15:0] current_pack1;
    logic signed [15:0] current_pack2;
    logic [7:0]         cell_flags;
    logic [7:0]         temp_flags;
    logic [7:0]         command;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0] relay_on;
    logic [1:0] fan_on;
    logic       charging;
    logic       discharging;
    logic [1:0] fault_current;
    logic [1:0] fault_voltage;
    logic [1:0] fault_temp;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/battery_pack_protection_controller_unit.sv =====
// top level of the two-pack battery protection controller
// a word is held in the input register, and its result moves into the result register
//   once that register is empty or its previous result is being taken
// throughput: one word per cycle; the input register advances whenever the
//   result register is empty or being taken in the same cycle
// reset: controller state and both valid flags clear, configuration returns to its defaults, no word is held
`default_nettype none

module battery_pack_protection_controller_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [14:0]          cfg_data_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [3:0]           button_levels_i,
  input  wire logic signed [15:0]   current_pack1_i,
  input  wire logic signed [15:0]   current_pack2_i,
  input  wire logic [7:0]           cell_flags_i,
  input  wire logic [7:0]           temp_flags_i,
  input  wire logic [7:0]           command_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      relay1_on_o,
  output logic                      relay2_on_o,
  output logic                      fan1_on_o,
  output logic                      fan2_on_o,
  output logic                      charging_o,
  output logic                      discharging_o,
  output logic                      fault_current1_o,
  output logic                      fault_current2_o,
  output logic                      fault_voltage1_o,
  output logic                      fault_voltage2_o,
  output logic                      fault_temp1_o,
  output logic                      fault_temp2_o
);

  import bppc_pkg::*;

  // configuration registers
  logic [CurW-1:0] max_chg_q, max_dchg_q;
  logic [CntW-1:0] win_ticks_q, press_thr_q;

  // pipeline registers
  logic  in_valid_q, out_valid_q;
  item_t item_q;
  res_t  res_q, res_d;
  logic  advance;

  // controller state
  logic [1:0]                relay_q, relay_d;
  logic [1:0]                fan_q, fan_d;
  logic [1:0]                cur_fault_q, cur_fault_d;
  logic [1:0]                volt_fault_q, volt_fault_d;
  logic [1:0]                temp_fault_q, temp_fault_d;
  logic                      chg_q, chg_d;
  logic                      dchg_q, dchg_d;
  logic [CntW-1:0]           win_cnt_q, win_cnt_d;
  logic [3:0][CntW-1:0]      press_cnt_q, press_cnt_d;

  // handshake
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chg_q   <= MAX_CHG_RST;
      max_dchg_q  <= MAX_DCHG_RST;
      win_ticks_q <= WIN_TICKS_RST;
      press_thr_q <= PRESS_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_MAX_CHG:   max_chg_q   <= cfg_data_i;
        CFG_MAX_DCHG:  max_dchg_q  <= cfg_data_i;
        CFG_WIN_TICKS: win_ticks_q <= cfg_data_i[CntW-1:0];
        CFG_PRESS_THR: press_thr_q <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.op            <= op_i;
      item_q.button_levels <= button_levels_i;
      item_q.current_pack1 <= current_pack1_i;
      item_q.current_pack2 <= current_pack2_i;
      item_q.cell_flags    <= cell_flags_i;
      item_q.temp_flags    <= temp_flags_i;
      item_q.command       <= command_i;
    end
  end

  // next state for the held word
  always_comb begin
    logic signed [15:0]   cur [2];
    logic signed [16:0]   neg;
    logic [CntW-1:0]      win_inc;
    logic [3:0][CntW-1:0] press_inc;
    logic [3:0]           tog;
    logic                 found;
    logic [1:0]           any_fault;

    relay_d      = relay_q;
    fan_d        = fan_q;
    cur_fault_d  = cur_fault_q;
    volt_fault_d = volt_fault_q;
    temp_fault_d = temp_fault_q;
    chg_d        = chg_q;
    dchg_d       = dchg_q;
    win_cnt_d    = win_cnt_q;
    press_cnt_d  = press_cnt_q;
    tog          = '0;
    found        = 1'b0;
    neg          = '0;
    cur[0]       = item_q.current_pack1;
    cur[1]       = item_q.current_pack2;

    // saturating counters for a tick
    win_inc = (win_cnt_q == CNT_MAX) ? win_cnt_q : win_cnt_q + 8'd1;
    for (int b = 0; b < 4; b++) begin
      press_inc[b] = (item_q.button_levels[b] && press_cnt_q[b] != CNT_MAX)
                     ? press_cnt_q[b] + 8'd1 : press_cnt_q[b];
    end

    case (op_e'(item_q.op))
      OP_TICK: begin
        win_cnt_d   = win_inc;
        press_cnt_d = press_inc;
        // window end: first button above threshold wins
        if (win_inc >= win_ticks_q) begin
          for (int b = 0; b < 4; b++) begin
            if (!found && press_inc[b] > press_thr_q) begin
              tog[b] = 1'b1;
              found  = 1'b1;
            end
          end
          win_cnt_d   = '0;
          press_cnt_d = '0;
        end
      end
      OP_MEASURE: begin
        // mode from current signs
        chg_d  = (cur[0] > 16'sd0) || (cur[1] > 16'sd0);
        dchg_d = !chg_d && (cur[0][15] || cur[1][15]);
        for (int p = 0; p < 2; p++) begin
          neg = -{cur[p][15], cur[p]};
          cur_fault_d[p] = (chg_d && (cur[p] > $signed({1'b0, max_chg_q}))) ||
                           (dchg_d && (neg > $signed({2'b00, max_dchg_q})));
          volt_fault_d[p] = |item_q.cell_flags[p*4 +: 4];
          temp_fault_d[p] = |item_q.temp_flags[p*4 +: 4];
          if (cur_fault_d[p] || volt_fault_d[p] || temp_fault_d[p]) begin
            relay_d[p] = 1'b0;
          end
          if (temp_fault_d[p]) begin
            fan_d[p] = 1'b1;
          end
        end
      end
      OP_COMMAND: begin
        case (item_q.command)
          CMD_RELAY1: tog = 4'b0001;
          CMD_RELAY2: tog = 4'b0010;
          CMD_FAN1:   tog = 4'b0100;
          CMD_FAN2:   tog = 4'b1000;
          default:    tog = 4'b0000;
        endcase
      end
      default: ;
    endcase

    // toggles with fault interlocks
    any_fault = cur_fault_q | volt_fault_q | temp_fault_q;
    for (int p = 0; p < 2; p++) begin
      if (tog[p]) begin
        relay_d[p] = !relay_q[p] && !any_fault[p];
      end
      if (tog[p+2]) begin
        fan_d[p] = !fan_q[p] || temp_fault_q[p];
      end
    end

    res_d.relay_on      = relay_d;
    res_d.fan_on        = fan_d;
    res_d.charging      = chg_d;
    res_d.discharging   = dchg_d;
    res_d.fault_current = cur_fault_d;
    res_d.fault_voltage = volt_fault_d;
    res_d.fault_temp    = temp_fault_d;
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q      <= '0;
      fan_q        <= '0;
      cur_fault_q  <= '0;
      volt_fault_q <= '0;
      temp_fault_q <= '0;
      chg_q        <= 1'b0;
      dchg_q       <= 1'b0;
      win_cnt_q    <= '0;
      press_cnt_q  <= '0;
    end else if (advance) begin
      relay_q      <= relay_d;
      fan_q        <= fan_d;
      cur_fault_q  <= cur_fault_d;
      volt_fault_q <= volt_fault_d;
      temp_fault_q <= temp_fault_d;
      chg_q        <= chg_d;
      dchg_q       <= dchg_d;
      win_cnt_q    <= win_cnt_d;
      press_cnt_q  <= press_cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // output ports
  assign out_valid_o      = out_valid_q;
  assign relay1_on_o      = res_q.relay_on[0];
  assign relay2_on_o      = res_q.relay_on[1];
  assign fan1_on_o        = res_q.fan_on[0];
  assign fan2_on_o        = res_q.fan_on[1];
  assign charging_o       = res_q.charging;
  assign discharging_o    = res_q.discharging;
  assign fault_current1_o = res_q.fault_current[0];
  assign fault_current2_o = res_q.fault_current[1];
  assign fault_voltage1_o = res_q.fault_voltage[0];
  assign fault_voltage2_o = res_q.fault_voltage[1];
  assign fault_temp1_o    = res_q.fault_temp[0];
  assign fault_temp2_o    = res_q.fault_temp[1];

  // a closed relay never coexists with a fault on its pack
  a_relay_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((relay_q & (cur_fault_q | volt_fault_q | temp_fault_q)) == 2'b00))
    else $error("relay closed on faulted pack");

  // a temperature fault keeps the fan running
  a_fan_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((temp_fault_q & ~fan_q) == 2'b00))
    else $error("fan off during temperature fault");

  // charge and discharge modes exclude each other
  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(chg_q && dchg_q))
    else $error("both modes set");

  // the window counter is cleared before it can reach saturation
  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_cnt_q != CNT_MAX)
    else $error("window counter saturated");

  // every word that moves on yields a held result
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

endmodule

`default_nettype wire
